@@ rtl/smeu_pkg.sv @@
// ----------------------------------------------------------------------------
// smeu_pkg
// Shared constants and codes for the stack machine execute unit.
// ----------------------------------------------------------------------------
package smeu_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int NUM_REGS    = 8;
  localparam int SP_W        = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int REG_W       = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  typedef logic [31:0] word_t;

  // operation codes
  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_MUL  = 4'd2;
  localparam logic [3:0] OP_DIV  = 4'd3;
  localparam logic [3:0] OP_SQRT = 4'd4;
  localparam logic [3:0] OP_OUT  = 4'd5;
  localparam logic [3:0] OP_IN   = 4'd6;
  localparam logic [3:0] OP_PUSHR = 4'd7;
  localparam logic [3:0] OP_POPR = 4'd8;
  localparam logic [3:0] OP_JMP  = 4'd9;
  localparam logic [3:0] OP_JB   = 4'd10;
  localparam logic [3:0] OP_JBE  = 4'd11;
  localparam logic [3:0] OP_JA   = 4'd12;
  localparam logic [3:0] OP_JAE  = 4'd13;
  localparam logic [3:0] OP_JE   = 4'd14;
  localparam logic [3:0] OP_JNE  = 4'd15;

  // status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_UNDER  = 3'd1;
  localparam logic [2:0] ST_OVER   = 3'd2;
  localparam logic [2:0] ST_DIV0   = 3'd3;
  localparam logic [2:0] ST_BADREG = 3'd4;
  localparam logic [2:0] ST_BADARG = 3'd5;

endpackage

@@ rtl/stack_machine_execute_unit.sv @@
// ----------------------------------------------------------------------------
// stack_machine_execute_unit
// Executes one stack-machine instruction per input transfer.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with func, in_value, reg_index and
// jump_target. One result transfer per instruction on res_valid / res_stall
// carrying status, out_valid, out_value, jump_taken and new_position.
// The operand stack lives in a synchronous memory; the top two entries are
// read one after the other through its one read port, so every instruction
// passes through the RD1, RD2 and EXEC states from acceptance to a result
// in the output register. Divide runs on a radix-2 divider of 32 steps and
// square root on a shared restoring root unit of 16 steps. One instruction
// is in flight at a time; the next is accepted once the result register is
// free or being taken. The user must write the slot limit through cfg_wr /
// cfg_data only while the unit is idle; the unit does not enforce this.
// Reset (rst, synchronous) empties the stack, clears the registers and
// the slot limit, and drops any pending result. Stack contents are not cleared.
// While res_stall is high the result is held unchanged.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [3:0]           func,
  input  logic signed [31:0]   in_value,
  input  logic [3:0]           reg_index,
  input  logic [15:0]          jump_target,
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic [2:0]           status,
  output logic                 out_valid,
  output logic signed [31:0]   out_value,
  output logic                 jump_taken,
  output logic [15:0]          new_position
);
  import smeu_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD1  = 3'd1;
  localparam logic [2:0] S_RD2  = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_ROOT = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]       state;
  logic [15:0]      slot_limit;
  logic [CNT_W-1:0] count;
  word_t            regs [NUM_REGS];
  word_t            mem  [STACK_DEPTH];
  word_t            rd_data;
  logic [SP_W-1:0]  rd_addr;
  logic             wr_en;
  logic [SP_W-1:0]  wr_addr;
  word_t            wr_data;

  // latched instruction
  logic [3:0]  op;
  word_t       ival;
  logic [3:0]  ridx;
  logic [15:0] tgt;
  word_t       top;
  word_t       second;

  // shared iterative unit
  logic [5:0]  step;
  word_t       acc;
  logic [32:0] rem;
  word_t       quo;
  logic        neg;

  logic        accept;
  logic        res_free;

  assign res_free = !res_valid || !res_stall;
  assign in_stall = (state != S_IDLE) || !res_free;
  assign accept   = in_valid && !in_stall;

  // stack memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    if (state == S_IDLE) begin
      rd_addr = SP_W'(count - CNT_W'(1));
    end else begin
      rd_addr = SP_W'(count - CNT_W'(2));
    end
  end

  // signed compare
  logic lt, eq, cond;
  assign lt = $signed(second) < $signed(top);
  assign eq = second == top;
  always_comb begin
    case (op)
      OP_JB:   cond = lt;
      OP_JBE:  cond = lt || eq;
      OP_JA:   cond = !lt && !eq;
      OP_JAE:  cond = !lt;
      OP_JE:   cond = eq;
      OP_JNE:  cond = !eq;
      default: cond = 1'b0;
    endcase
  end

  word_t ma, mb, prod;
  assign ma   = second[31] ? (32'd0 - second) : second;
  assign mb   = top[31] ? (32'd0 - top) : top;
  assign prod = second * top;

  // one divide / root step
  logic [32:0] dtrial;
  logic [33:0] rtrial;
  logic [33:0] rrem;
  assign dtrial = {rem[31:0], acc[31]} - {1'b0, mb};
  assign rrem   = {rem[31:0], acc[31:30]};
  assign rtrial = rrem - {quo[31:0], 2'b01};

  // write-back port driven in exec / fin
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = SP_W'(count - CNT_W'(2));
    wr_data = second + top;
    if (state == S_EXEC) begin
      case (op)
        OP_ADD: begin
          wr_en = count >= CNT_W'(2);
        end
        OP_SUB: begin
          wr_en   = count >= CNT_W'(2);
          wr_data = second - top;
        end
        OP_MUL: begin
          wr_en   = count >= CNT_W'(2);
          wr_data = prod;
        end
        OP_IN, OP_PUSHR: begin
          wr_addr = SP_W'(count);
          wr_data = (op == OP_IN) ? ival : regs[REG_W'(ridx)];
          wr_en   = (count < CNT_W'(STACK_DEPTH)) &&
                    ((op == OP_IN) || (ridx < 4'(NUM_REGS)));
        end
        default: wr_en = 1'b0;
      endcase
    end else if (state == S_FIN) begin
      wr_en = 1'b1;
      if (op == OP_SQRT) begin
        wr_addr = SP_W'(count - CNT_W'(1));
        wr_data = quo;
      end else begin
        wr_data = neg ? (32'd0 - quo) : quo;
      end
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      slot_limit <= '0;
      res_valid  <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= '0;
      end
    end else begin
      if (cfg_wr) begin
        slot_limit <= cfg_data;
      end
      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op    <= func;
            ival  <= in_value;
            ridx  <= reg_index;
            tgt   <= jump_target;
            state <= S_RD1;
          end
        end
        S_RD1: begin
          top   <= (count >= CNT_W'(1)) ? rd_data : '0;
          state <= S_RD2;
        end
        S_RD2: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          status       <= ST_OK;
          out_valid    <= 1'b0;
          out_value    <= '0;
          jump_taken   <= 1'b0;
          new_position <= '0;
          state        <= S_IDLE;
          res_valid    <= 1'b1;
          case (op)
            OP_ADD, OP_SUB, OP_MUL: begin
              if (count < CNT_W'(2)) begin
                status <= ST_UNDER;
              end else begin
                count <= count - CNT_W'(1);
              end
            end
            OP_DIV: begin
              if (count < CNT_W'(2)) begin
                status <= ST_UNDER;
              end else if (top == '0) begin
                status <= ST_DIV0;
              end else begin
                acc       <= ma;
                rem       <= '0;
                quo       <= '0;
                neg       <= second[31] ^ top[31];
                step      <= '0;
                state     <= S_DIV;
                res_valid <= 1'b0;
              end
            end
            OP_SQRT: begin
              if (count < CNT_W'(1)) begin
                status <= ST_UNDER;
              end else if (top[31]) begin
                status <= ST_BADARG;
              end else begin
                acc       <= top;
                rem       <= '0;
                quo       <= '0;
                step      <= '0;
                state     <= S_ROOT;
                res_valid <= 1'b0;
              end
            end
            OP_OUT: begin
              if (count >= CNT_W'(1)) begin
                out_valid <= 1'b1;
                out_value <= top;
                count     <= count - CNT_W'(1);
              end
            end
            OP_IN, OP_PUSHR: begin
              if (op == OP_PUSHR && ridx >= 4'(NUM_REGS)) begin
                status <= ST_BADREG;
              end else if (count >= CNT_W'(STACK_DEPTH)) begin
                status <= ST_OVER;
              end else begin
                count <= count + CNT_W'(1);
              end
            end
            OP_POPR: begin
              if (count >= CNT_W'(1)) begin
                if (ridx >= 4'(NUM_REGS)) begin
                  status <= ST_BADREG;
                end else begin
                  regs[REG_W'(ridx)] <= top;
                  count <= count - CNT_W'(1);
                end
              end
            end
            OP_JMP: begin
              if (tgt > slot_limit) begin
                status <= ST_BADARG;
              end else begin
                jump_taken   <= 1'b1;
                new_position <= tgt;
              end
            end
            default: begin
              if (count < CNT_W'(2)) begin
                status <= ST_UNDER;
              end else if (!cond) begin
                count <= count - CNT_W'(2);
              end else if (tgt > slot_limit) begin
                status <= ST_BADARG;
              end else begin
                count        <= count - CNT_W'(2);
                jump_taken   <= 1'b1;
                new_position <= tgt;
              end
            end
          endcase
        end
        S_DIV: begin
          // restoring divide, one quotient bit a cycle
          acc <= {acc[30:0], 1'b0};
          if (!dtrial[32]) begin
            rem <= {1'b0, dtrial[31:0]};
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= {rem[31:0], acc[31]};
            quo <= {quo[30:0], 1'b0};
          end
          step <= step + 6'd1;
          if (step == 6'd31) begin
            state <= S_FIN;
          end
        end
        S_ROOT: begin
          // restoring root, one result bit per pair of operand bits
          acc <= {acc[29:0], 2'b00};
          if (!rtrial[33]) begin
            rem <= rtrial[32:0];
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= rrem[32:0];
            quo <= {quo[30:0], 1'b0};
          end
          step <= step + 6'd1;
          if (step == 6'd15) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (op == OP_DIV) begin
            count <= count - CNT_W'(1);
          end
          state     <= S_IDLE;
          res_valid <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // second operand comes out of the memory in the cycle after the top
  always_ff @(posedge clk) begin
    if (state == S_RD2) begin
      second <= (count >= CNT_W'(2)) ? rd_data : '0;
    end
  end

endmodule

@@ tb/stack_machine_execute_unit_tb.sv @@
// ----------------------------------------------------------------------------
// stack_machine_execute_unit_tb
// Self-checking testbench: a queue-fed driver sends instructions, a local
// model of the stack and registers predicts each result, and a monitor
// compares every result transfer field by field. The slot limit is changed
// between phases while the unit is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module stack_machine_execute_unit_tb;
  import smeu_pkg::*;

  typedef struct packed {
    logic [3:0]  func;
    logic [31:0] value;
    logic [3:0]  ridx;
    logic [15:0] target;
  } instr_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        ovalid;
    logic [31:0] oval;
    logic        jtaken;
    logic [15:0] npos;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr = 1'b0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] func = '0;
  logic signed [31:0] in_value = '0;
  logic [3:0] reg_index = '0;
  logic [15:0] jump_target = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic [2:0] status;
  logic out_valid;
  logic signed [31:0] out_value;
  logic jump_taken;
  logic [15:0] new_position;

  instr_t  pending_instrs[$];
  result_t expected_results[$];
  int      mismatch_count = 0;
  bit      drive_enable = 1'b0;
  bit      in_accepted = 1'b0;
  int      in_gap = 0;
  int      out_gap = 0;

  // model state
  logic [31:0] mdl_stack[STACK_DEPTH];
  int          mdl_count;
  logic [31:0] mdl_regs[NUM_REGS];
  logic [15:0] mdl_slot_limit;

  stack_machine_execute_unit u_dut (
    .clk(clk), .rst(rst), .cfg_wr(cfg_wr), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .func(func),
    .in_value(in_value), .reg_index(reg_index), .jump_target(jump_target),
    .res_valid(res_valid), .res_stall(res_stall), .status(status),
    .out_valid(out_valid), .out_value(out_value), .jump_taken(jump_taken),
    .new_position(new_position)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] isqrt(logic [31:0] v);
    logic [31:0] res;
    logic [31:0] bitv;
    res = 0;
    bitv = 32'h4000_0000;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] sdiv(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  // advance the model by one instruction
  function automatic result_t execute_instr(instr_t it);
    result_t r;
    logic [31:0] top;
    logic [31:0] second;
    logic [31:0] v;
    logic cond;
    r = '0;
    top = (mdl_count >= 1) ? mdl_stack[mdl_count-1] : '0;
    second = (mdl_count >= 2) ? mdl_stack[mdl_count-2] : '0;
    case (it.func)
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (mdl_count < 2) r.status = ST_UNDER;
        else if (it.func == OP_DIV && top == 0) r.status = ST_DIV0;
        else begin
          case (it.func)
            OP_ADD: v = second + top;
            OP_SUB: v = second - top;
            OP_MUL: v = second * top;
            default: v = sdiv(second, top);
          endcase
          mdl_count--;
          mdl_stack[mdl_count-1] = v;
        end
      end
      OP_SQRT: begin
        if (mdl_count < 1) r.status = ST_UNDER;
        else if (top[31]) r.status = ST_BADARG;
        else mdl_stack[mdl_count-1] = isqrt(top);
      end
      OP_OUT: begin
        if (mdl_count >= 1) begin
          r.ovalid = 1'b1;
          r.oval = top;
          mdl_count--;
        end
      end
      OP_IN, OP_PUSHR: begin
        if (it.func == OP_PUSHR && it.ridx >= NUM_REGS) r.status = ST_BADREG;
        else if (mdl_count >= STACK_DEPTH) r.status = ST_OVER;
        else begin
          mdl_stack[mdl_count] =
            (it.func == OP_IN) ? it.value : mdl_regs[REG_W'(it.ridx)];
          mdl_count++;
        end
      end
      OP_POPR: begin
        if (mdl_count >= 1) begin
          if (it.ridx >= NUM_REGS) r.status = ST_BADREG;
          else begin
            mdl_regs[REG_W'(it.ridx)] = top;
            mdl_count--;
          end
        end
      end
      OP_JMP: begin
        if (it.target > mdl_slot_limit) r.status = ST_BADARG;
        else begin
          r.jtaken = 1'b1;
          r.npos = it.target;
        end
      end
      default: begin
        if (mdl_count < 2) r.status = ST_UNDER;
        else begin
          case (it.func)
            OP_JB:   cond = $signed(second) <  $signed(top);
            OP_JBE:  cond = $signed(second) <= $signed(top);
            OP_JA:   cond = $signed(second) >  $signed(top);
            OP_JAE:  cond = $signed(second) >= $signed(top);
            OP_JE:   cond = second == top;
            default: cond = second != top;
          endcase
          if (!cond) mdl_count -= 2;
          else if (it.target > mdl_slot_limit) r.status = ST_BADARG;
          else begin
            mdl_count -= 2;
            r.jtaken = 1'b1;
            r.npos = it.target;
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // input driver: new transfer or hold at the falling edge
  always @(negedge clk) begin
    if (!rst && drive_enable) begin
      if (in_valid && !in_accepted) begin
        // hold the stalled payload
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_instrs.size() > 0) begin
        instr_t it;
        it = pending_instrs.pop_front();
        expected_results.push_back(execute_instr(it));
        func <= it.func;
        in_value <= it.value;
        reg_index <= it.ridx;
        jump_target <= it.target;
        in_valid <= 1'b1;
        in_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // note: the model runs when the item is presented; only one is in flight,
  // and a presented item is always eventually accepted, so order holds.
  // the accept edge is tracked so the driver moves on after a transfer
  always @(posedge clk) begin
    in_accepted <= in_valid && !in_stall;
  end

  // result stall generator
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
      if ($urandom_range(0, 9) < 3) out_gap <= pick_gap();
    end
  end

  // monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      result_t exp_r;
      result_t act_r;
      act_r = '{status, out_valid, out_value, jump_taken, new_position};
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result transfer %p", act_r);
      end else begin
        exp_r = expected_results.pop_front();
        if (act_r !== exp_r) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %p actual %p", exp_r, act_r);
        end
      end
    end
  end

  function automatic instr_t rand_instr(bit well_formed);
    instr_t it;
    int p;
    it.value = $urandom();
    p = $urandom_range(0, 9);
    if (p < 3) it.value = $signed($urandom_range(0, 200)) - 100;
    else if (p == 3) it.value = $urandom_range(0, 1) ? 32'h8000_0000 : 32'hFFFF_FFFF;
    it.target = $urandom_range(0, 3) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 300));
    if (well_formed) begin
      it.ridx = 4'($urandom_range(0, NUM_REGS - 1));
      p = $urandom_range(0, 99);
      if (mdl_count < 4 || p < 30) it.func = $urandom_range(0, 1) ? OP_IN : OP_PUSHR;
      else it.func = 4'($urandom_range(0, 15));
      if (mdl_count > 50 && p < 60) it.func = 4'($urandom_range(0, 5));
    end else begin
      it.func = 4'($urandom_range(0, 15));
      it.ridx = 4'($urandom_range(0, 15));
    end
    return it;
  endfunction

  task automatic send(logic [3:0] f, logic [31:0] v, logic [3:0] r, logic [15:0] t);
    instr_t it;
    it = '{f, v, r, t};
    pending_instrs.push_back(it);
  endtask

  task automatic wait_idle();
    while (pending_instrs.size() > 0 || expected_results.size() > 0 || in_valid)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_slot_limit(logic [15:0] v);
    @(negedge clk);
    cfg_wr <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_wr <= 1'b0;
    mdl_slot_limit = v;
  endtask

  initial begin
    int n;
    mdl_count = 0;
    mdl_slot_limit = '0;
    foreach (mdl_regs[i]) mdl_regs[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    write_slot_limit(16'd100);
    drive_enable = 1'b1;

    // directed: underflows, extremes, divide by zero, bad register and bad argument
    send(OP_ADD, 0, 0, 0);
    send(OP_SQRT, 0, 0, 0);
    send(OP_OUT, 0, 0, 0);
    send(OP_POPR, 0, 4'd15, 0);
    send(OP_JE, 0, 0, 0);
    send(OP_IN, 32'h8000_0000, 0, 0);
    send(OP_IN, 32'hFFFF_FFFF, 0, 0);
    send(OP_DIV, 0, 0, 0);
    send(OP_IN, 32'h7FFF_FFFF, 0, 0);
    send(OP_IN, 0, 0, 0);
    send(OP_DIV, 0, 0, 0);
    send(OP_PUSHR, 0, 4'd9, 0);
    send(OP_PUSHR, 0, 4'd3, 0);
    send(OP_MUL, 0, 0, 0);
    send(OP_SQRT, 0, 0, 0);
    send(OP_ADD, 0, 0, 0);
    send(OP_SQRT, 0, 0, 0);
    send(OP_POPR, 0, 4'd8, 0);
    send(OP_POPR, 0, 4'd7, 0);
    send(OP_JMP, 0, 0, 16'd101);
    send(OP_JMP, 0, 0, 16'd100);
    send(OP_IN, 5, 0, 0);
    send(OP_IN, 5, 0, 0);
    send(OP_JE, 0, 0, 16'hFFFF);
    send(OP_JNE, 0, 0, 16'd3);
    wait_idle();

    // fill to overflow
    for (int i = 0; i < STACK_DEPTH + 2; i++) send(OP_IN, $urandom(), 0, 0);
    send(OP_PUSHR, 0, 4'd1, 0);
    send(OP_SUB, 0, 0, 0);
    wait_idle();

    // random phases over several slot limit settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_slot_limit(16'd0);
        1: write_slot_limit(16'hFFFF);
        2: write_slot_limit(16'($urandom_range(1, 400)));
        default: write_slot_limit(16'd150);
      endcase
      for (int i = 0; i < 190; i++) begin
        instr_t it;
        // predict stack depth roughly: generation uses model count at queue time
        it = rand_instr($urandom_range(0, 9) < 8);
        pending_instrs.push_back(it);
        while (pending_instrs.size() > 0) @(posedge clk);
      end
      wait_idle();
    end
    drive_enable = 1'b0;
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("stack_machine_execute_unit verification clean");
    end else begin
      $display("stack_machine_execute_unit verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("stack_machine_execute_unit verification failed");
    $finish;
  end

endmodule
